[sv/psfp_pkg.sv]
`timescale 1ns / 1ps
// Package for the PCM sample format packer.
// Holds the format codes, register indexes and the log8 byte encoder.

package psfp_pkg;

	localparam int FMT_W  = 3;
	localparam int CHAN_W = 4;
	localparam int CFG_W  = 4;

	typedef logic [FMT_W-1:0] fmt_t;

	localparam fmt_t FMT_U8     = 3'd0;
	localparam fmt_t FMT_S8     = 3'd1;
	localparam fmt_t FMT_U16_BE = 3'd2;
	localparam fmt_t FMT_S16_BE = 3'd3;
	localparam fmt_t FMT_U16_LE = 3'd4;
	localparam fmt_t FMT_S16_LE = 3'd5;
	localparam fmt_t FMT_LOG8   = 3'd6;
	localparam fmt_t FMT_NONE   = 3'd7;

	localparam logic REG_SAMPLE_FORMAT = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam fmt_t            FMT_RESET  = FMT_S16_BE;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd1;

	// Log byte: the exponent counts down from 7 while bit 14 of the
	// shifted magnitude is clear; the mantissa is bits 13..10 after the shift.
	function automatic logic [7:0] log8_encode(input logic [15:0] pat);
		logic        neg;
		logic [16:0] mag;
		logic [16:0] sh;
		logic [2:0]  expo;
		logic        found;
		logic [7:0]  val;
		neg   = pat[15];
		mag   = neg ? (17'h10000 - {1'b0, pat}) : {1'b0, pat};
		expo  = 3'd0;
		sh    = mag << 7;
		found = 1'b0;
		for (int k = 0; k < 7; k++) begin
			if (!found && mag[14-k]) begin
				found = 1'b1;
				expo  = 3'(7 - k);
				sh    = mag << k;
			end
		end
		val = {neg, expo, sh[13:10]};
		return ~val;
	endfunction

endpackage

[sv/pcm_sample_format_packer.sv]
`timescale 1ns / 1ps
// Top level of the PCM sample format packer.
// Depends on psfp_pkg for format codes, register indexes and the log encoder.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one signed 16-bit
//   amplitude per request. The master channel (m_tvalid, m_tready, m_tdata,
//   m_tlast) delivers the formatted bytes, one per request, and m_tlast marks
//   the final byte that belongs to one sample.
//   A sample produces channel_count copies of its byte group (one or two
//   bytes, depending on sample_format), channel_count saturating at
//   MAX_CHANNELS. With format none or zero channels a sample is taken and
//   produces nothing.
//   The first byte of a sample passes from the emitter stage into the output
//   register. Throughput: one byte per cycle from the output register while
//   the receiver does not stall; a sample occupies the byte emitter for
//   channels * bytes-per-group bytes, and a mono 8-bit stream takes a sample
//   every cycle. The next sample is taken in the same cycle that the last
//   byte of the current one moves into the output register.
//   When the receiver stalls, the output register holds its byte and the
//   emitter and input stop behind it. Reset empties both stages and sets
//   the format to S16 big-endian with one channel.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant to be issued while the block is idle.

module pcm_sample_format_packer #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic signed [15:0]          s_tdata,  // [15:0] amplitude
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // [7:0] data_byte
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [psfp_pkg::CFG_W-1:0]  cfg_data
);

	import psfp_pkg::*;

	localparam int CW = $clog2(MAX_CHANNELS + 1);

	fmt_t              fmt_q;
	logic [CHAN_W-1:0] chan_q;

	// Emitter stage: one sample's byte group and its remaining channel count.
	logic          valid_s1;
	logic [7:0]    grp0_s1;
	logic [7:0]    grp1_s1;
	logic          two_s1;
	logic          sel_s1;
	logic [CW-1:0] left_s1;

	logic [15:0]   pat;
	logic [15:0]   off;
	logic [7:0]    grp0_d;
	logic [7:0]    grp1_d;
	logic          two_d;
	logic          has_d;
	logic [CW-1:0] chans_d;
	logic          out_free;
	logic          last_s1;
	logic          emit;
	logic          take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_RESET;
			chan_q <= CHAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_FORMAT: fmt_q  <= cfg_data[FMT_W-1:0];
				REG_CHANNEL_COUNT: chan_q <= cfg_data[CHAN_W-1:0];
			endcase
		end
	end

	assign pat = s_tdata;
	assign off = {~pat[15], pat[14:0]};

	always_comb begin
		grp0_d = 8'h00;
		grp1_d = 8'h00;
		two_d  = 1'b0;
		has_d  = 1'b1;
		unique case (fmt_q)
			FMT_U8:     grp0_d = off[15:8];
			FMT_S8:     grp0_d = pat[15:8];
			FMT_U16_BE: begin grp0_d = off[15:8]; grp1_d = off[7:0]; two_d = 1'b1; end
			FMT_S16_BE: begin grp0_d = pat[15:8]; grp1_d = pat[7:0]; two_d = 1'b1; end
			FMT_U16_LE: begin grp0_d = off[7:0]; grp1_d = off[15:8]; two_d = 1'b1; end
			FMT_S16_LE: begin grp0_d = pat[7:0]; grp1_d = pat[15:8]; two_d = 1'b1; end
			FMT_LOG8:   grp0_d = log8_encode(pat);
			default:    has_d  = 1'b0;
		endcase
		if (chan_q > CHAN_W'(MAX_CHANNELS))
			chans_d = CW'(MAX_CHANNELS);
		else
			chans_d = chan_q[CW-1:0];
	end

	assign out_free = !m_tvalid || m_tready;
	assign last_s1  = (left_s1 == CW'(1)) && (sel_s1 == two_s1);
	assign emit     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || (out_free && last_s1);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= has_d && (chans_d != '0);
		end else if (emit && last_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp0_s1 <= grp0_d;
			grp1_s1 <= grp1_d;
			two_s1  <= two_d;
			sel_s1  <= 1'b0;
			left_s1 <= chans_d;
		end else if (emit) begin
			if (sel_s1 == two_s1) begin
				sel_s1  <= 1'b0;
				left_s1 <= left_s1 - CW'(1);
			end else begin
				sel_s1  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= sel_s1 ? grp1_s1 : grp0_s1;
			m_tlast <= last_s1;
		end
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |-> !s_tready)
		else $error("input taken while the emitter is stalled");

	a_silent_item_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (fmt_q == FMT_NONE || chan_q == '0)) |=> !valid_s1)
		else $error("sample with no output bytes entered the emitter");

	a_channel_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (left_s1 != '0 && left_s1 <= CW'(MAX_CHANNELS)))
		else $error("emitter channel count out of range");

	a_last_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_s1 && !take) |=> !valid_s1)
		else $error("emitter kept a sample after its last byte");

endmodule
